// ===== rtl/core/sgrad_pkg.sv =====
// ----------------------------------------------------------------------------
// sgrad_pkg - shared types and constants for the SGR attribute decoder
// Holds the decoded operation codes, the queue word layout and the fixed
// code values of the select graphic rendition parameter set.
// ----------------------------------------------------------------------------
`default_nettype none

package sgrad_pkg;

	// Field widths fixed by the interface
	localparam int unsigned PARAM_W  = 16;
	localparam int unsigned ATTR_W   = 6;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;

	// Decoupling queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Code values
	localparam logic [PARAM_W-1:0] CODE_RESET     = 16'd0;
	localparam logic [PARAM_W-1:0] CODE_SET_LAST  = 16'd8;
	localparam logic [PARAM_W-1:0] CODE_CLR_ALL   = 16'd22;
	localparam logic [PARAM_W-1:0] CODE_CLR_FIRST = 16'd21;
	localparam logic [PARAM_W-1:0] CODE_CLR_LAST  = 16'd28;
	localparam logic [PARAM_W-1:0] CODE_FG_RGB    = 16'd38;
	localparam logic [PARAM_W-1:0] CODE_BG_RGB    = 16'd48;
	localparam logic [PARAM_W-1:0] CODE_FG_DEF    = 16'd39;
	localparam logic [PARAM_W-1:0] CODE_BG_DEF    = 16'd49;
	localparam logic [PARAM_W-1:0] CODE_CLR_BASE  = 16'd20;
	localparam logic [PARAM_W-1:0] FG_BASE        = 16'd30;
	localparam logic [PARAM_W-1:0] FG_LAST        = 16'd37;
	localparam logic [PARAM_W-1:0] BG_BASE        = 16'd40;
	localparam logic [PARAM_W-1:0] BG_LAST        = 16'd47;
	localparam logic [PARAM_W-1:0] FG_BRIGHT_BASE = 16'd90;
	localparam logic [PARAM_W-1:0] FG_BRIGHT_LAST = 16'd97;
	localparam logic [PARAM_W-1:0] BG_BRIGHT_BASE = 16'd100;
	localparam logic [PARAM_W-1:0] BG_BRIGHT_LAST = 16'd107;

	// Bright codes just past each colour range, rejected as bad
	localparam logic [PARAM_W-1:0] FG_BRIGHT_BAD_LO = 16'd98;
	localparam logic [PARAM_W-1:0] FG_BRIGHT_BAD_HI = 16'd99;
	localparam logic [PARAM_W-1:0] BG_BRIGHT_BAD_LO = 16'd108;
	localparam logic [PARAM_W-1:0] BG_BRIGHT_BAD_HI = 16'd109;

	// Colour index values
	localparam logic [BYTE_W-1:0] IDX_DEFAULT     = 8'd0;
	localparam logic [BYTE_W-1:0] IDX_NORMAL      = 8'd1;
	localparam logic [BYTE_W-1:0] IDX_NORMAL_LAST = 8'd8;
	localparam logic [BYTE_W-1:0] IDX_BRIGHT      = 8'd11;
	localparam logic [BYTE_W-1:0] IDX_BRIGHT_LAST = 8'd18;
	localparam logic [BYTE_W-1:0] IDX_RGB         = 8'd255;
	localparam logic [BYTE_W-1:0] COMP_MAX        = 8'd255;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD           = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FIRST_UNKNOWN = 2'd2;

	// RGB collection phases (values still expected)
	localparam logic [1:0] RGB_NONE  = 2'd0;
	localparam logic [1:0] RGB_BLUE  = 2'd1;
	localparam logic [1:0] RGB_GREEN = 2'd2;
	localparam logic [1:0] RGB_RED   = 2'd3;

	// Decoded operation of one parameter taken as a code
	typedef enum logic [3:0] {
		OP_RESET,
		OP_SET_FLAG,
		OP_CLR_FLAG,
		OP_CLR_ALL,
		OP_RGB_START,
		OP_FG_IDX,
		OP_BG_IDX,
		OP_BAD_BRIGHT,
		OP_UNKNOWN
	} op_t;

	// One classified parameter word as held in the queue
	typedef struct packed {
		op_t               op;
		logic [ATTR_W-1:0] mask;
		logic [BYTE_W-1:0] idx;
		logic              rgb_bg;
		logic [BYTE_W-1:0] comp;
		logic              last;
		logic              screen;
	} item_t;

	// Packed colour: index plus RGB
	typedef struct packed {
		logic [BYTE_W-1:0] idx;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} colour_t;

	// Queue handshake between the parts
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Flag bit for set/clear codes 1..8
	function automatic logic [ATTR_W-1:0] flag_mask(input logic [3:0] n);
		logic [ATTR_W-1:0] m;
		m = '0;
		unique case (n)
			4'd1:    m = 6'b000001;
			4'd3:    m = 6'b000010;
			4'd4:    m = 6'b000100;
			4'd5:    m = 6'b001000;
			4'd7:    m = 6'b010000;
			4'd8:    m = 6'b100000;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sgr_attribute_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// sgr_attribute_decoder_unit - SGR parameter decoder, top level
// Input channel: one SGR parameter word per handshake (in_valid/in_stall)
//   with param, is_last, no_params and screen_select.
// Output channel: one result word per sequence (out_valid/out_stall) with
//   the selected screen's attributes, fg/bg index and RGB, and status.
// A front part classifies each word and pushes it into a two-word queue;
// a back part applies it to the screen format and registers the result.
// Throughput: one word per cycle while the queue is not full, set by the
// update of the per-screen format registers in the back part.
// A last word is written into the queue, then popped by the back part,
//   which loads the result word and out_valid into the output register.
// When out_stall holds a result, the back part keeps taking non-last words;
//   a last word waits in the queue and in_stall rises once the queue fills.
// Reset clears every screen's format to defaults, the sequence state, the
// queue and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_attribute_decoder_unit import sgrad_pkg::*; #(
	parameter int unsigned NUM_SCREENS = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [PARAM_W-1:0]  param,
	input  wire logic                is_last,
	input  wire logic                no_params,
	input  wire logic                screen_select,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [ATTR_W-1:0]        attributes,
	output logic [BYTE_W-1:0]        fg_index,
	output logic [BYTE_W-1:0]        fg_red,
	output logic [BYTE_W-1:0]        fg_green,
	output logic [BYTE_W-1:0]        fg_blue,
	output logic [BYTE_W-1:0]        bg_index,
	output logic [BYTE_W-1:0]        bg_red,
	output logic [BYTE_W-1:0]        bg_green,
	output logic [BYTE_W-1:0]        bg_blue,
	output logic [STATUS_W-1:0]      status
);

	queue_stat_t qstat;
	logic        push;
	logic        pop;
	item_t       push_item;
	item_t       pop_item;

	// Front: accept and classify
	sgrad_front #(.NUM_SCREENS(NUM_SCREENS)) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.param         (param),
		.is_last       (is_last),
		.no_params     (no_params),
		.screen_select (screen_select),
		.qstat         (qstat),
		.push          (push),
		.push_item     (push_item)
	);

	// Decoupling queue
	sgrad_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	// Back: update format and emit result
	sgrad_back #(.NUM_SCREENS(NUM_SCREENS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.attributes (attributes),
		.fg_index   (fg_index),
		.fg_red     (fg_red),
		.fg_green   (fg_green),
		.fg_blue    (fg_blue),
		.bg_index   (bg_index),
		.bg_red     (bg_red),
		.bg_green   (bg_green),
		.bg_blue    (bg_blue),
		.status     (status)
	);

endmodule

`default_nettype wire

// ===== rtl/core/sgrad_front.sv =====
// ----------------------------------------------------------------------------
// sgrad_front - input acceptance and parameter classification
// Takes one parameter word a cycle while the queue is not full, classifies
// it as a code and as an RGB component, and pushes the result into the decoupling queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrad_front import sgrad_pkg::*; #(
	parameter int unsigned NUM_SCREENS = 2
) (
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [PARAM_W-1:0] param,
	input  wire logic               is_last,
	input  wire logic               no_params,
	input  wire logic               screen_select,
	input  wire queue_stat_t        qstat,
	output logic                    push,
	output item_t                   push_item
);

	logic [PARAM_W-1:0] p;
	logic [BYTE_W-1:0]  lo;

	// Handshake: stall only on a full queue
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	// Empty sequence acts as code 0
	assign p  = no_params ? CODE_RESET : param;
	assign lo = p[BYTE_W-1:0];

	// Classify
	always_comb begin
		push_item        = '0;
		push_item.op     = OP_UNKNOWN;
		push_item.last   = no_params || is_last;
		push_item.screen = (NUM_SCREENS > 1) ? screen_select : 1'b0;
		push_item.rgb_bg = (p == CODE_BG_RGB);
		push_item.comp   = (|p[PARAM_W-1:BYTE_W]) ? COMP_MAX : lo;
		priority if (p == CODE_RESET) begin
			push_item.op = OP_RESET;
		end else if (p <= CODE_SET_LAST) begin
			push_item.mask = flag_mask(p[3:0]);
			push_item.op   = (flag_mask(p[3:0]) != '0) ? OP_SET_FLAG : OP_UNKNOWN;
		end else if (p == CODE_CLR_ALL) begin
			push_item.op = OP_CLR_ALL;
		end else if (p >= CODE_CLR_FIRST && p <= CODE_CLR_LAST) begin
			push_item.mask = flag_mask(4'(p - CODE_CLR_BASE));
			push_item.op   = (flag_mask(4'(p - CODE_CLR_BASE)) != '0) ?
				OP_CLR_FLAG : OP_UNKNOWN;
		end else if (p == CODE_FG_RGB || p == CODE_BG_RGB) begin
			push_item.op = OP_RGB_START;
		end else if (p == CODE_FG_DEF) begin
			push_item.op  = OP_FG_IDX;
			push_item.idx = IDX_DEFAULT;
		end else if (p == CODE_BG_DEF) begin
			push_item.op  = OP_BG_IDX;
			push_item.idx = IDX_DEFAULT;
		end else if (p >= FG_BASE && p <= FG_LAST) begin
			push_item.op  = OP_FG_IDX;
			push_item.idx = lo - FG_BASE[BYTE_W-1:0] + IDX_NORMAL;
		end else if (p >= BG_BASE && p <= BG_LAST) begin
			push_item.op  = OP_BG_IDX;
			push_item.idx = lo - BG_BASE[BYTE_W-1:0] + IDX_NORMAL;
		end else if (p >= FG_BRIGHT_BASE && p <= FG_BRIGHT_LAST) begin
			push_item.op  = OP_FG_IDX;
			push_item.idx = lo - FG_BRIGHT_BASE[BYTE_W-1:0] + IDX_BRIGHT;
		end else if (p >= BG_BRIGHT_BASE && p <= BG_BRIGHT_LAST) begin
			push_item.op  = OP_BG_IDX;
			push_item.idx = lo - BG_BRIGHT_BASE[BYTE_W-1:0] + IDX_BRIGHT;
		end else if (p == FG_BRIGHT_BAD_LO || p == FG_BRIGHT_BAD_HI ||
				p == BG_BRIGHT_BAD_LO || p == BG_BRIGHT_BAD_HI) begin
			push_item.op = OP_BAD_BRIGHT;
		end else begin
			push_item.op = OP_UNKNOWN;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sgrad_queue.sv =====
// ----------------------------------------------------------------------------
// sgrad_queue - short word queue between front and back
// Ring of QUEUE_DEPTH classified words with read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrad_queue import sgrad_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      pop_item,
	output queue_stat_t qstat
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_item    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sgrad_back.sv =====
// ----------------------------------------------------------------------------
// sgrad_back - format update and result output
// Pops classified words, applies them to the per-screen format state and
// the sequence state, and registers one result word per sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrad_back import sgrad_pkg::*; #(
	parameter int unsigned NUM_SCREENS = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire queue_stat_t  qstat,
	input  wire item_t        pop_item,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [ATTR_W-1:0]   attributes,
	output logic [BYTE_W-1:0]   fg_index,
	output logic [BYTE_W-1:0]   fg_red,
	output logic [BYTE_W-1:0]   fg_green,
	output logic [BYTE_W-1:0]   fg_blue,
	output logic [BYTE_W-1:0]   bg_index,
	output logic [BYTE_W-1:0]   bg_red,
	output logic [BYTE_W-1:0]   bg_green,
	output logic [BYTE_W-1:0]   bg_blue,
	output logic [STATUS_W-1:0] status
);

	localparam int unsigned SCR_W = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;

	// Per-screen format
	logic [ATTR_W-1:0] attr_q [NUM_SCREENS];
	colour_t           fg_q   [NUM_SCREENS];
	colour_t           bg_q   [NUM_SCREENS];

	// Sequence state
	logic [1:0]          pending_q;
	logic                target_bg_q;
	logic [BYTE_W-1:0]   part_red_q;
	logic [BYTE_W-1:0]   part_green_q;
	logic                stopped_q;
	logic [STATUS_W-1:0] seq_status_q;
	logic                started_q;

	// Output register
	logic                out_valid_q;
	logic [ATTR_W-1:0]   attr_out_q;
	colour_t             fg_out_q;
	colour_t             bg_out_q;
	logic [STATUS_W-1:0] status_out_q;

	logic [SCR_W-1:0]    scr;
	logic [ATTR_W-1:0]   attr_n;
	colour_t             fg_n;
	colour_t             bg_n;
	colour_t             rgb_word;
	logic [1:0]          pending_n;
	logic                target_bg_n;
	logic [BYTE_W-1:0]   part_red_n;
	logic [BYTE_W-1:0]   part_green_n;
	logic                stopped_n;
	logic [STATUS_W-1:0] seq_status_n;
	logic                started_n;
	logic [STATUS_W-1:0] result_status;
	logic                load;

	assign scr  = SCR_W'(pop_item.screen);
	assign pop  = !qstat.empty && (!pop_item.last || !out_valid_q || !out_stall);
	assign load = pop && pop_item.last;

	assign rgb_word = '{idx: IDX_RGB, red: part_red_q, green: part_green_q,
		blue: pop_item.comp};

	// Apply one word
	always_comb begin
		attr_n       = attr_q[scr];
		fg_n         = fg_q[scr];
		bg_n         = bg_q[scr];
		pending_n    = pending_q;
		target_bg_n  = target_bg_q;
		part_red_n   = part_red_q;
		part_green_n = part_green_q;
		stopped_n    = stopped_q;
		seq_status_n = seq_status_q;
		started_n    = started_q;
		if (!stopped_q) begin
			if (pending_q != RGB_NONE) begin
				unique case (pending_q)
					RGB_RED: begin
						part_red_n = pop_item.comp;
						pending_n  = RGB_GREEN;
					end
					RGB_GREEN: begin
						part_green_n = pop_item.comp;
						pending_n    = RGB_BLUE;
					end
					default: begin
						if (target_bg_q) begin
							bg_n = rgb_word;
						end else begin
							fg_n = rgb_word;
						end
						pending_n = RGB_NONE;
						started_n = 1'b1;
					end
				endcase
			end else begin
				unique case (pop_item.op)
					OP_RESET: begin
						attr_n     = '0;
						fg_n.idx   = IDX_DEFAULT;
						bg_n.idx   = IDX_DEFAULT;
						started_n  = 1'b1;
					end
					OP_SET_FLAG: begin
						attr_n    = attr_q[scr] | pop_item.mask;
						started_n = 1'b1;
					end
					OP_CLR_FLAG: begin
						attr_n    = attr_q[scr] & ~pop_item.mask;
						started_n = 1'b1;
					end
					OP_CLR_ALL: begin
						attr_n    = '0;
						started_n = 1'b1;
					end
					OP_RGB_START: begin
						pending_n   = RGB_RED;
						target_bg_n = pop_item.rgb_bg;
					end
					OP_FG_IDX: begin
						fg_n.idx  = pop_item.idx;
						started_n = 1'b1;
					end
					OP_BG_IDX: begin
						bg_n.idx  = pop_item.idx;
						started_n = 1'b1;
					end
					OP_BAD_BRIGHT: begin
						stopped_n    = 1'b1;
						seq_status_n = ST_BAD;
					end
					default: begin
						stopped_n    = 1'b1;
						seq_status_n = started_q ? ST_BAD : ST_FIRST_UNKNOWN;
					end
				endcase
			end
		end
		// Sequence ending inside an RGB triple
		if (!stopped_n && pending_n != RGB_NONE) begin
			result_status = started_n ? ST_BAD : ST_FIRST_UNKNOWN;
		end else begin
			result_status = seq_status_n;
		end
	end

	// Format and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SCREENS; i++) begin
				attr_q[i] <= '0;
				fg_q[i]   <= '0;
				bg_q[i]   <= '0;
			end
			pending_q    <= RGB_NONE;
			target_bg_q  <= 1'b0;
			stopped_q    <= 1'b0;
			seq_status_q <= ST_OK;
			started_q    <= 1'b0;
		end else if (pop) begin
			attr_q[scr] <= attr_n;
			fg_q[scr]   <= fg_n;
			bg_q[scr]   <= bg_n;
			if (pop_item.last) begin
				pending_q    <= RGB_NONE;
				target_bg_q  <= 1'b0;
				stopped_q    <= 1'b0;
				seq_status_q <= ST_OK;
				started_q    <= 1'b0;
			end else begin
				pending_q    <= pending_n;
				target_bg_q  <= target_bg_n;
				stopped_q    <= stopped_n;
				seq_status_q <= seq_status_n;
				started_q    <= started_n;
			end
		end
	end

	// Partial RGB components
	always_ff @(posedge clk) begin
		if (pop) begin
			part_red_q   <= part_red_n;
			part_green_q <= part_green_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (load) begin
			attr_out_q   <= attr_n;
			fg_out_q     <= fg_n;
			bg_out_q     <= bg_n;
			status_out_q <= result_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign attributes = attr_out_q;
	assign fg_index   = fg_out_q.idx;
	assign fg_red     = fg_out_q.red;
	assign fg_green   = fg_out_q.green;
	assign fg_blue    = fg_out_q.blue;
	assign bg_index   = bg_out_q.idx;
	assign bg_red     = bg_out_q.red;
	assign bg_green   = bg_out_q.green;
	assign bg_blue    = bg_out_q.blue;
	assign status     = status_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/sgrad_checker.sv =====
// ----------------------------------------------------------------------------
// sgrad_checker - port-level checks for the SGR decoder
// Watches the top level's output channel and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrad_checker import sgrad_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [ATTR_W-1:0]   attributes,
	input wire logic [BYTE_W-1:0]   fg_index,
	input wire logic [BYTE_W-1:0]   bg_index,
	input wire logic [STATUS_W-1:0] status
);

	// Stalled result word stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(attributes) && $stable(fg_index)
			&& $stable(bg_index) && $stable(status))
		else $error("result word changed while stalled");

	// Status only takes defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_BAD || status == ST_FIRST_UNKNOWN)
		else $error("undefined status code");

	// Colour indices only from the defined sets
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fg_index <= IDX_NORMAL_LAST
			|| (fg_index >= IDX_BRIGHT && fg_index <= IDX_BRIGHT_LAST)
			|| fg_index == IDX_RGB) && (bg_index <= IDX_NORMAL_LAST
			|| (bg_index >= IDX_BRIGHT && bg_index <= IDX_BRIGHT_LAST)
			|| bg_index == IDX_RGB))
		else $error("colour index outside the defined sets");

endmodule

bind sgr_attribute_decoder_unit sgrad_checker u_sgrad_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.attributes (attributes),
	.fg_index   (fg_index),
	.bg_index   (bg_index),
	.status     (status)
);

`default_nettype wire

// ===== bench/sgr_format_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_format_checker - scoreboard for the SGR attribute decoder
// Watches both channels of the decoder. Every accepted input word is run
// through a local model of the per-screen format state. Each word that ends
// a sequence queues the expected format. Each accepted result is compared
// field by field with the oldest queued format.
// ----------------------------------------------------------------------------

module sgr_format_checker import sgrad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [PARAM_W-1:0]  param,
	input  logic                is_last,
	input  logic                no_params,
	input  logic                screen_select,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [ATTR_W-1:0]   attributes,
	input  logic [BYTE_W-1:0]   fg_index,
	input  logic [BYTE_W-1:0]   fg_red,
	input  logic [BYTE_W-1:0]   fg_green,
	input  logic [BYTE_W-1:0]   fg_blue,
	input  logic [BYTE_W-1:0]   bg_index,
	input  logic [BYTE_W-1:0]   bg_red,
	input  logic [BYTE_W-1:0]   bg_green,
	input  logic [BYTE_W-1:0]   bg_blue,
	input  logic [STATUS_W-1:0] status,
	output int                  mismatch_total,
	output int                  formats_due,
	output int                  formats_checked
);

	// codes per group: flag codes 1-8, colour codes base+0 to base+7
	localparam int GROUP_SIZE = 8;

	// flag set codes; the clear codes sit twenty above
	localparam logic [4:0] SGR_BOLD      = 5'd1;
	localparam logic [4:0] SGR_ITALIC    = 5'd3;
	localparam logic [4:0] SGR_UNDERLINE = 5'd4;
	localparam logic [4:0] SGR_BLINK     = 5'd5;
	localparam logic [4:0] SGR_INVERSE   = 5'd7;
	localparam logic [4:0] SGR_INVISIBLE = 5'd8;

	typedef enum logic [1:0] {
		DEC_DONE,
		DEC_BRIGHT_BAD,
		DEC_UNKNOWN
	} verdict_t;

	typedef struct packed {
		logic [ATTR_W-1:0]   attributes;
		colour_t             fg;
		colour_t             bg;
		logic [STATUS_W-1:0] status;
	} format_t;

	// per-screen format
	logic [ATTR_W-1:0] flags_q [2];
	colour_t           fore_q [2];
	colour_t           back_q [2];

	// sequence state
	logic [1:0]          rgb_left;
	logic                rgb_to_bg;
	logic [BYTE_W-1:0]   red_hold;
	logic [BYTE_W-1:0]   green_hold;
	logic                halted;
	logic                begun;
	logic [STATUS_W-1:0] halt_status;

	format_t formats_q [$];
	format_t fresh;
	format_t want;
	logic    emits;
	int      errors = 0;
	int      checked = 0;
	int      due_count = 0;
	int      k;

	assign mismatch_total  = errors;
	assign formats_due     = due_count;
	assign formats_checked = checked;

	function automatic logic [ATTR_W-1:0] flag_bit(input logic [4:0] n);
		case (n)
			SGR_BOLD:      return 6'b000001;
			SGR_ITALIC:    return 6'b000010;
			SGR_UNDERLINE: return 6'b000100;
			SGR_BLINK:     return 6'b001000;
			SGR_INVERSE:   return 6'b010000;
			SGR_INVISIBLE: return 6'b100000;
			default:       return '0;
		endcase
	endfunction

	function automatic colour_t with_index(input colour_t c, input logic [BYTE_W-1:0] i);
		colour_t r;
		r = c;
		r.idx = i;
		return r;
	endfunction

	task automatic clear_sequence();
		rgb_left = RGB_NONE;
		rgb_to_bg = 1'b0;
		red_hold = '0;
		green_hold = '0;
		halted = 1'b0;
		begun = 1'b0;
		halt_status = ST_OK;
	endtask

	// Apply one word to the format model; a closing word yields a format
	task automatic apply_word(input logic [PARAM_W-1:0] raw, input logic last_in,
			input logic empty_in, input logic scr, output logic emits_o,
			output format_t fmt);
		logic [PARAM_W-1:0] code;
		logic [PARAM_W-1:0] offset;
		logic               closes;
		logic [BYTE_W-1:0]  comp;
		logic [ATTR_W-1:0]  bit_m;
		verdict_t           v;
		code = empty_in ? CODE_RESET : raw;
		closes = empty_in | last_in;
		v = DEC_DONE;
		emits_o = 1'b0;
		fmt = '0;
		if (!halted) begin
			if (rgb_left != RGB_NONE) begin
				// colour component, saturated to one byte
				comp = (code > COMP_MAX) ? COMP_MAX : code[BYTE_W-1:0];
				case (rgb_left)
					RGB_RED: begin
						red_hold = comp;
						rgb_left = RGB_GREEN;
					end
					RGB_GREEN: begin
						green_hold = comp;
						rgb_left = RGB_BLUE;
					end
					default: begin
						if (rgb_to_bg)
							back_q[scr] = {IDX_RGB, red_hold, green_hold, comp};
						else
							fore_q[scr] = {IDX_RGB, red_hold, green_hold, comp};
						rgb_left = RGB_NONE;
						begun = 1'b1;
					end
				endcase
			end else begin
				if (code == CODE_RESET) begin
					flags_q[scr] = '0;
					fore_q[scr] = with_index(fore_q[scr], IDX_DEFAULT);
					back_q[scr] = with_index(back_q[scr], IDX_DEFAULT);
				end else if (code <= GROUP_SIZE) begin
					bit_m = flag_bit(code[4:0]);
					if (bit_m == '0)
						v = DEC_UNKNOWN;
					else
						flags_q[scr] = flags_q[scr] | bit_m;
				end else if (code == CODE_CLR_ALL) begin
					flags_q[scr] = '0;
				end else if (code > CODE_CLR_BASE && code <= CODE_CLR_BASE + GROUP_SIZE) begin
					offset = code - CODE_CLR_BASE;
					bit_m = flag_bit(offset[4:0]);
					if (bit_m == '0)
						v = DEC_UNKNOWN;
					else
						flags_q[scr] = flags_q[scr] & ~bit_m;
				end else if (code == CODE_FG_RGB || code == CODE_BG_RGB) begin
					rgb_left = RGB_RED;
					rgb_to_bg = (code == CODE_BG_RGB);
				end else if (code == CODE_FG_DEF) begin
					fore_q[scr] = with_index(fore_q[scr], IDX_DEFAULT);
				end else if (code == CODE_BG_DEF) begin
					back_q[scr] = with_index(back_q[scr], IDX_DEFAULT);
				end else if (code >= FG_BASE && code < FG_BASE + GROUP_SIZE) begin
					offset = code - FG_BASE;
					fore_q[scr] = with_index(fore_q[scr], IDX_NORMAL + offset[BYTE_W-1:0]);
				end else if (code >= BG_BASE && code < BG_BASE + GROUP_SIZE) begin
					offset = code - BG_BASE;
					back_q[scr] = with_index(back_q[scr], IDX_NORMAL + offset[BYTE_W-1:0]);
				end else if (code >= FG_BRIGHT_BASE && code < FG_BRIGHT_BASE + GROUP_SIZE) begin
					offset = code - FG_BRIGHT_BASE;
					fore_q[scr] = with_index(fore_q[scr], IDX_BRIGHT + offset[BYTE_W-1:0]);
				end else if (code >= BG_BRIGHT_BASE && code < BG_BRIGHT_BASE + GROUP_SIZE) begin
					offset = code - BG_BRIGHT_BASE;
					back_q[scr] = with_index(back_q[scr], IDX_BRIGHT + offset[BYTE_W-1:0]);
				end else if ((code >= FG_BRIGHT_BASE + GROUP_SIZE &&
						code <= FG_BRIGHT_BASE + GROUP_SIZE + 1) ||
						(code >= BG_BRIGHT_BASE + GROUP_SIZE &&
						code <= BG_BRIGHT_BASE + GROUP_SIZE + 1)) begin
					v = DEC_BRIGHT_BAD;
				end else begin
					v = DEC_UNKNOWN;
				end
				// a bad code stops the rest of the sequence
				if (v == DEC_DONE) begin
					if (rgb_left == RGB_NONE)
						begun = 1'b1;
				end else begin
					halted = 1'b1;
					halt_status = (v == DEC_BRIGHT_BAD || begun) ? ST_BAD : ST_FIRST_UNKNOWN;
				end
			end
		end
		if (closes) begin
			fmt.attributes = flags_q[scr];
			fmt.fg = fore_q[scr];
			fmt.bg = back_q[scr];
			// an unfinished RGB triple counts as a bad sequence
			if (!halted && rgb_left != RGB_NONE)
				fmt.status = begun ? ST_BAD : ST_FIRST_UNKNOWN;
			else
				fmt.status = halt_status;
			emits_o = 1'b1;
			clear_sequence();
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Track accepted words and results at the clock edge
	always @(posedge clk) begin
		if (!arst_n) begin
			for (k = 0; k < 2; k++) begin
				flags_q[k] = '0;
				fore_q[k] = '0;
				back_q[k] = '0;
			end
			clear_sequence();
			formats_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				apply_word(param, is_last, no_params, screen_select, emits, fresh);
				if (emits)
					formats_q.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				if (formats_q.size() == 0) begin
					$display("%0t: result word with none expected, expected nothing, %s",
						$realtime, "actual word below");
					$display("%0t: actual %0d/%0d/%0d status %0d",
						$realtime, attributes, fg_index, bg_index, status);
					errors++;
				end else begin
					want = formats_q.pop_front();
					check_field("attributes", int'(want.attributes), int'(attributes));
					check_field("fg_index", int'(want.fg.idx), int'(fg_index));
					check_field("fg_red", int'(want.fg.red), int'(fg_red));
					check_field("fg_green", int'(want.fg.green), int'(fg_green));
					check_field("fg_blue", int'(want.fg.blue), int'(fg_blue));
					check_field("bg_index", int'(want.bg.idx), int'(bg_index));
					check_field("bg_red", int'(want.bg.red), int'(bg_red));
					check_field("bg_green", int'(want.bg.green), int'(bg_green));
					check_field("bg_blue", int'(want.bg.blue), int'(bg_blue));
					check_field("status", int'(want.status), int'(status));
					checked++;
				end
			end
		end
		due_count = formats_q.size();
	end

endmodule

// ===== bench/sgr_attribute_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_attribute_decoder_unit_test - testbench top for the SGR decoder
// Drives parameter words on the input channel and stalls the result channel
// at random; a short directed set of codes comes first, then random
// sequences with RGB triples, bad codes, cut-short sequences and screen
// changes. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------

module sgr_attribute_decoder_unit_test;
	import sgrad_pkg::*;

	localparam int CYCLE_NS    = 12;
	localparam int GROUP_SIZE  = 8;
	localparam int WORD_TARGET = 750;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_BURST  = 60;

	logic                clk = 1'b1;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [PARAM_W-1:0]  param = '0;
	logic                is_last = 1'b0;
	logic                no_params = 1'b0;
	logic                screen_select = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ATTR_W-1:0]   attributes;
	logic [BYTE_W-1:0]   fg_index;
	logic [BYTE_W-1:0]   fg_red;
	logic [BYTE_W-1:0]   fg_green;
	logic [BYTE_W-1:0]   fg_blue;
	logic [BYTE_W-1:0]   bg_index;
	logic [BYTE_W-1:0]   bg_red;
	logic [BYTE_W-1:0]   bg_green;
	logic [BYTE_W-1:0]   bg_blue;
	logic [STATUS_W-1:0] status;

	int mismatches;
	int formats_due;
	int formats_checked;
	int words_sent = 0;
	int sequences_sent = 0;
	int hold_asks = 0;
	int holds_given = 0;
	bit rush = 1'b0;
	bit tx_calm = 1'b0;

	always begin
		#(CYCLE_NS / 2) clk = 1'b0;
		#(CYCLE_NS / 2) clk = 1'b1;
	end

	sgr_attribute_decoder_unit #(
		.NUM_SCREENS(2)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.param(param),
		.is_last(is_last),
		.no_params(no_params),
		.screen_select(screen_select),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.attributes(attributes),
		.fg_index(fg_index),
		.fg_red(fg_red),
		.fg_green(fg_green),
		.fg_blue(fg_blue),
		.bg_index(bg_index),
		.bg_red(bg_red),
		.bg_green(bg_green),
		.bg_blue(bg_blue),
		.status(status)
	);

	sgr_format_checker format_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.param(param),
		.is_last(is_last),
		.no_params(no_params),
		.screen_select(screen_select),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.attributes(attributes),
		.fg_index(fg_index),
		.fg_red(fg_red),
		.fg_green(fg_green),
		.fg_blue(fg_blue),
		.bg_index(bg_index),
		.bg_red(bg_red),
		.bg_green(bg_green),
		.bg_blue(bg_blue),
		.status(status),
		.mismatch_total(mismatches),
		.formats_due(formats_due),
		.formats_checked(formats_checked)
	);

	// Offer one word after a random gap and hold it until taken
	task automatic send_word(input logic [PARAM_W-1:0] value, input logic closes,
			input logic empty, input logic scr);
		int gap;
		if (words_sent % 50 == 0)
			tx_calm = ($urandom_range(0, 2) == 0);
		gap = (rush || tx_calm) ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		param <= value;
		is_last <= closes;
		no_params <= empty;
		screen_select <= scr;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		words_sent++;
		if (closes || empty)
			sequences_sent++;
	endtask

	// Stop offering and wait until every expected format has come out
	task automatic drain_pause();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (formats_due == 0);
	endtask

	// Mostly valid codes, with bad bright codes and unknown values mixed in
	function automatic logic [PARAM_W-1:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return CODE_RESET;
		else if (r < 20)
			return PARAM_W'(CODE_RESET + $urandom_range(1, GROUP_SIZE));
		else if (r < 26)
			return PARAM_W'(CODE_CLR_BASE + $urandom_range(1, GROUP_SIZE));
		else if (r < 28)
			return CODE_CLR_ALL;
		else if (r < 38)
			return PARAM_W'(FG_BASE + $urandom_range(0, GROUP_SIZE - 1));
		else if (r < 48)
			return PARAM_W'(BG_BASE + $urandom_range(0, GROUP_SIZE - 1));
		else if (r < 56)
			return PARAM_W'(FG_BRIGHT_BASE + $urandom_range(0, GROUP_SIZE + 1));
		else if (r < 64)
			return PARAM_W'(BG_BRIGHT_BASE + $urandom_range(0, GROUP_SIZE + 1));
		else if (r < 70)
			return $urandom_range(0, 1) ? CODE_FG_DEF : CODE_BG_DEF;
		else if (r < 86)
			return $urandom_range(0, 1) ? CODE_FG_RGB : CODE_BG_RGB;
		else if (r < 94)
			return PARAM_W'($urandom_range(0, 127));
		else
			return PARAM_W'($urandom_range(0, 65535));
	endfunction

	// Colour component, with the saturation edge hit often
	function automatic logic [PARAM_W-1:0] pick_component();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return PARAM_W'(COMP_MAX);
		else if (r == 1)
			return PARAM_W'(COMP_MAX + 1);
		else if (r == 2)
			return PARAM_W'($urandom_range(256, 65535));
		else if (r == 3)
			return '1;
		else
			return PARAM_W'($urandom_range(0, 255));
	endfunction

	// One random sequence; a few are empty or end inside an RGB triple
	task automatic send_sequence();
		int   n;
		int   i;
		int   j;
		int   cut;
		logic scr;
		logic fin;
		logic [PARAM_W-1:0] code;
		scr = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 19) == 0) begin
			send_word(PARAM_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				1'b1, scr);
			return;
		end
		n = $urandom_range(1, 5);
		for (i = 0; i < n; i++) begin
			fin = (i == n - 1);
			if ($urandom_range(0, 9) == 0)
				scr = ~scr;
			code = pick_code();
			if (code == CODE_FG_RGB || code == CODE_BG_RGB) begin
				cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : 3;
				if (cut < 3) begin
					send_word(code, cut == 0, 1'b0, scr);
					for (j = 0; j < cut; j++)
						send_word(pick_component(), j == cut - 1, 1'b0, scr);
					return;
				end
				send_word(code, 1'b0, 1'b0, scr);
				for (j = 0; j < 3; j++) begin
					if ($urandom_range(0, 9) == 0)
						scr = ~scr;
					send_word(pick_component(), fin && j == 2, 1'b0, scr);
				end
			end else begin
				send_word(code, fin, 1'b0, scr);
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		int n;
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty sequence, every flag set and clear code alone
		send_word('1, 1'b0, 1'b1, 1'b0);
		for (n = 1; n <= GROUP_SIZE; n++)
			send_word(PARAM_W'(CODE_RESET + n), 1'b1, 1'b0, n[0]);
		for (n = 1; n <= GROUP_SIZE; n++)
			send_word(PARAM_W'(CODE_CLR_BASE + n), 1'b1, 1'b0, n[0]);
		// full foreground triple with saturation
		send_word(CODE_FG_RGB, 1'b0, 1'b0, 1'b1);
		send_word('0, 1'b0, 1'b0, 1'b1);
		send_word(PARAM_W'(COMP_MAX), 1'b0, 1'b0, 1'b1);
		send_word('1, 1'b1, 1'b0, 1'b1);
		// background triple cut short as the first code
		send_word(CODE_BG_RGB, 1'b0, 1'b0, 1'b0);
		send_word(PARAM_W'(COMP_MAX + 1), 1'b1, 1'b0, 1'b0);
		// bad bright code after progress
		send_word(FG_BASE, 1'b0, 1'b0, 1'b0);
		send_word(PARAM_W'(FG_BRIGHT_BASE + GROUP_SIZE), 1'b1, 1'b0, 1'b0);
		drain_pause();

		// random sequences, with one long output hold and one full drain
		while (words_sent < WORD_TARGET) begin
			if (!held && words_sent >= 300) begin
				held = 1'b1;
				hold_asks++;
				rush = 1'b1;
				repeat (HOLD_BURST)
					send_word(pick_code(), 1'b1, 1'b0, 1'($urandom_range(0, 1)));
				rush = 1'b0;
			end
			if (!paused && words_sent >= 550) begin
				paused = 1'b1;
				drain_pause();
			end
			send_sequence();
		end

		drain_pause();
		repeat (20) @(posedge clk);
		$display("Sent %0d parameter words in %0d sequences over both screens;",
			words_sent, sequences_sent);
		$display("%0d formats checked, covering RGB triples, bad and unknown codes,",
			formats_checked);
		$display("a long output hold and a full drain.");
		if (mismatches == 0 && formats_due == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result side: random stall before each word, one long hold on request
	initial begin
		int gap;
		int served;
		bit calm;
		served = 0;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if (served % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (holds_given != hold_asks) begin
				gap = HOLD_CYCLES;
				holds_given++;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 17);
			end
			@(negedge clk);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			forever begin
				@(posedge clk);
				if (out_valid)
					break;
			end
			served++;
		end
	end

	// Watchdog
	initial begin
		#(CYCLE_NS * 300000);
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sgr_attribute_decoder_unit.f =====
rtl/core/sgrad_pkg.sv
rtl/core/sgrad_front.sv
rtl/core/sgrad_queue.sv
rtl/core/sgrad_back.sv
rtl/core/sgr_attribute_decoder_unit.sv
rtl/core/sgrad_checker.sv
bench/sgr_format_checker.sv
bench/sgr_attribute_decoder_unit_test.sv
